[hw/rtl/nts_pkg.sv]
// Shared constants, types and a helper function of the nearest timestamp search block.
package nts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int STAMP_W     = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    // Signed search bounds: one extra bit over the count so that -1 is representable.
    localparam int POS_W       = CNT_W + 1;
    localparam int OUT_W       = 10;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 16;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_N1,
        ST_N2,
        ST_N3,
        ST_DEC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
    } result_t;

    function automatic logic [STAMP_W-1:0] abs_diff(input logic [STAMP_W-1:0] a,
                                                    input logic [STAMP_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

[hw/rtl/nts_stamp_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
module nts_stamp_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/nts_search_fsm.sv]
// Sequencer: table fill count, binary search over the stamp memory and neighbor decision.
module nts_search_fsm (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_kind,
    input  logic [nts_pkg::STAMP_W-1:0]         in_time,
    output nts_pkg::result_t                    result,
    input  logic                                res_ready,
    output logic                                ram_we,
    output logic [nts_pkg::IDX_W-1:0]           ram_waddr,
    output logic [nts_pkg::STAMP_W-1:0]         ram_wdata,
    output logic [nts_pkg::IDX_W-1:0]           ram_raddr,
    input  logic [nts_pkg::STAMP_W-1:0]         ram_rdata
);

    localparam int IDX_W   = nts_pkg::IDX_W;
    localparam int CNT_W   = nts_pkg::CNT_W;
    localparam int POS_W   = nts_pkg::POS_W;
    localparam int STAMP_W = nts_pkg::STAMP_W;

    nts_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [STAMP_W-1:0]        time_reg, time_next;
    logic signed [POS_W-1:0]   lo_reg, lo_next;
    logic signed [POS_W-1:0]   hi_reg, hi_next;
    logic signed [POS_W-1:0]   mid_reg, mid_next;
    logic [STAMP_W-1:0]        d1_reg, d1_next;
    logic [STAMP_W-1:0]        d2_reg, d2_next;
    logic [STAMP_W-1:0]        d3_reg, d3_next;
    logic [IDX_W-1:0]          res_reg, res_next;

    logic signed [POS_W-1:0]   lo_c, hi_c, mid_c, hi_c_m1;
    logic signed [POS_W:0]     sum_c;
    logic                      go_step;
    logic [CNT_W-1:0]          nxt_cnt;
    logic                      has_next;
    logic [IDX_W-1:0]          hi_idx, hm1_idx, nxt_idx, fb_idx;

    // Neighbor positions around the closed search range.
    assign hi_idx   = hi_reg[IDX_W-1:0];
    assign hm1_idx  = hi_idx - IDX_W'(1);
    assign nxt_cnt  = CNT_W'(hi_idx) + CNT_W'(1);
    assign nxt_idx  = nxt_cnt[IDX_W-1:0];
    assign has_next = nxt_cnt < count_reg;
    assign fb_idx   = has_next ? nxt_idx : hi_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nts_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        time_reg <= time_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        d3_reg   <= d3_next;
        res_reg  <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        time_next  = time_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;
        d3_next    = d3_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[IDX_W-1:0];
        ram_wdata  = in_time;
        ram_raddr  = '0;
        lo_c       = lo_reg;
        hi_c       = hi_reg;
        go_step    = 1'b0;

        unique case (state_reg)
            nts_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (in_kind == nts_pkg::KIND_QUERY) begin
                        time_next = in_time;
                        lo_c      = '0;
                        hi_c      = $signed({1'b0, count_reg}) - $signed(POS_W'(1));
                        go_step   = 1'b1;
                    end else if (count_reg < CNT_W'(nts_pkg::TABLE_DEPTH)) begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            nts_pkg::ST_CMP: begin
                if (time_reg == ram_rdata) begin
                    res_next   = mid_reg[IDX_W-1:0];
                    state_next = nts_pkg::ST_DONE;
                end else begin
                    if (time_reg < ram_rdata) begin
                        hi_c = mid_reg - $signed(POS_W'(1));
                    end else begin
                        lo_c = mid_reg + $signed(POS_W'(1));
                    end
                    go_step = 1'b1;
                end
            end
            nts_pkg::ST_N1: begin
                d1_next    = nts_pkg::abs_diff(time_reg, ram_rdata);
                ram_raddr  = hi_idx;
                state_next = nts_pkg::ST_N2;
            end
            nts_pkg::ST_N2: begin
                d2_next    = nts_pkg::abs_diff(time_reg, ram_rdata);
                ram_raddr  = nxt_idx;
                state_next = nts_pkg::ST_N3;
            end
            nts_pkg::ST_N3: begin
                d3_next    = has_next ? nts_pkg::abs_diff(time_reg, ram_rdata) : d2_reg;
                state_next = nts_pkg::ST_DEC;
            end
            nts_pkg::ST_DEC: begin
                if (d1_reg < d2_reg) begin
                    res_next = (d1_reg < d3_reg) ? hm1_idx : fb_idx;
                end else begin
                    res_next = (d2_reg < d3_reg) ? hi_idx : fb_idx;
                end
                state_next = nts_pkg::ST_DONE;
            end
            nts_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = nts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nts_pkg::ST_IDLE;
            end
        endcase

        // One halving step: check the bounds, then finish with index zero or issue the next memory read.
        sum_c   = {lo_c[POS_W-1], lo_c} + {hi_c[POS_W-1], hi_c};
        mid_c   = sum_c[POS_W:1];
        hi_c_m1 = hi_c - $signed(POS_W'(1));
        if (go_step) begin
            lo_next = lo_c;
            hi_next = hi_c;
            if (hi_c <= $signed(POS_W'(0))) begin
                res_next   = '0;
                state_next = nts_pkg::ST_DONE;
            end else if (lo_c >= hi_c) begin
                ram_raddr  = hi_c_m1[IDX_W-1:0];
                state_next = nts_pkg::ST_N1;
            end else begin
                mid_next   = mid_c;
                ram_raddr  = mid_c[IDX_W-1:0];
                state_next = nts_pkg::ST_CMP;
            end
        end
    end

    assign in_ready     = (state_reg == nts_pkg::ST_IDLE);
    assign result.valid = (state_reg == nts_pkg::ST_DONE);
    assign result.index = res_reg;

`ifndef SYNTH
    a_no_result_while_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> !in_ready)
        else $error("result offered while the sequencer takes requests");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(nts_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && in_kind == nts_pkg::KIND_QUERY) |=> !in_ready)
        else $error("query request did not start a search");

    a_load_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && in_kind == nts_pkg::KIND_LOAD
         && count_reg < CNT_W'(nts_pkg::TABLE_DEPTH))
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted load did not advance the entry count");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.valid && !res_ready) |=> result.valid && $stable(result.index))
        else $error("pending result changed before the output stage took it");
`endif

endmodule

[hw/rtl/nearest_timestamp_search.sv]
// Top level of the nearest timestamp search block: stream ports, stamp memory and output stage.
//
// The block keeps an ascending table of up to TABLE_DEPTH 32-bit timestamps in one
// simple dual-port memory and answers nearest-index queries by binary search. A load
// request (tuser = 0) appends its timestamp; loads past a full table are dropped. A
// query request (tuser = 1) runs k halving steps (at most about log2 of the entry
// count, 10 for a full 1024-entry table): each step costs one read through the
// memory's single registered read port, and closing the range costs three neighbor
// reads and a decision state. An exact hit ends the search early, and a table of
// zero or one entries answers index zero without a memory read. A finished index
// moves into an output register, so the next request is taken while it waits for
// m_tready. No clearing pass is needed after reset: the fill count bounds every
// read whose data is used.
module nearest_timestamp_search (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [nts_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] time_value
    input  logic [0:0]                     s_tuser,   // [0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nts_pkg::M_TDATA_W-1:0]  m_tdata    // [9:0] nearest_index, [15:10] zero
);

    localparam int IDX_W   = nts_pkg::IDX_W;
    localparam int STAMP_W = nts_pkg::STAMP_W;

    nts_pkg::result_t    result;
    logic                res_ready;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [STAMP_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [STAMP_W-1:0]  ram_rdata;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [IDX_W-1:0]    m_index_reg, m_index_next;

    nts_search_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser[0]),
        .in_time   (s_tdata[STAMP_W-1:0]),
        .result    (result),
        .res_ready (res_ready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    nts_stamp_ram #(
        .DEPTH  (nts_pkg::TABLE_DEPTH),
        .WIDTH  (STAMP_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The output register accepts a new index when empty or when it drains this cycle.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_index_next  = m_index_reg;
        if (result.valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_index_next  = result.index;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_index_reg <= m_index_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = nts_pkg::M_TDATA_W'(nts_pkg::OUT_W'(m_index_reg));

endmodule

[test/nearest_timestamp_search_checker.sv]
// Checker for the nearest timestamp search block: tracks the stamp table and checks every query result.
module nearest_timestamp_search_checker
    import nts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] time_value
    input  logic [0:0]           s_tuser,   // [0] kind
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [9:0] nearest_index, [15:10] zero
    output int                   fail_count,
    output int                   pending_results
);

    logic [STAMP_W-1:0]   stamp_mem [TABLE_DEPTH];
    int                   stamp_count;
    logic [M_TDATA_W-1:0] index_queue [$];
    int                   mismatch_total;

    assign fail_count = mismatch_total;

    function automatic logic [STAMP_W-1:0] stored_at(input int pos);
        if (pos < 0 || pos >= stamp_count)
            return '0;
        return stamp_mem[pos];
    endfunction

    function automatic logic [STAMP_W-1:0] span(input logic [STAMP_W-1:0] a,
                                                 input logic [STAMP_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Binary search with the three-way neighbor decision once the range has closed.
    function automatic logic [OUT_W-1:0] nearest_index_of(input logic [STAMP_W-1:0] t);
        int                 lo;
        int                 hi;
        int                 mid;
        int                 fallback;
        int                 pick;
        bit                 has_above;
        logic [STAMP_W-1:0] probe;
        logic [STAMP_W-1:0] d_below;
        logic [STAMP_W-1:0] d_at;
        logic [STAMP_W-1:0] d_above;
        lo = 0;
        hi = stamp_count - 1;
        while (1) begin
            if (hi <= 0)
                return '0;
            if (lo >= hi)
                break;
            mid   = (lo + hi) / 2;
            probe = stored_at(mid);
            if (t == probe)
                return mid[OUT_W-1:0];
            if (t < probe)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        has_above = (hi + 1 < stamp_count);
        d_below   = span(t, stored_at(hi - 1));
        d_at      = span(t, stored_at(hi));
        d_above   = has_above ? span(t, stored_at(hi + 1)) : d_at;
        fallback  = has_above ? hi + 1 : hi;
        if (d_below < d_at)
            pick = (d_below < d_above) ? hi - 1 : fallback;
        else
            pick = (d_at < d_above) ? hi : fallback;
        return pick[OUT_W-1:0];
    endfunction

    task automatic note_failure(input string what, input logic [M_TDATA_W-1:0] want,
                                input logic [M_TDATA_W-1:0] got);
        mismatch_total++;
        if (mismatch_total <= 10)
            $display("ERROR: %s: expected nearest_index %0d (0x%04h), got %0d (0x%04h)",
                     what, want[OUT_W-1:0], want, got[OUT_W-1:0], got);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            stamp_count = 0;
            index_queue.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (index_queue.size() == 0)
                    note_failure("result with no query waiting", 'x, m_tdata);
                else if (m_tdata !== index_queue[0])
                    note_failure("result mismatch", index_queue.pop_front(), m_tdata);
                else
                    void'(index_queue.pop_front());
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == KIND_QUERY) begin
                    index_queue.push_back(
                        M_TDATA_W'(nearest_index_of(s_tdata[STAMP_W-1:0])));
                end else if (stamp_count < TABLE_DEPTH) begin
                    // Loads into a full table are dropped.
                    stamp_mem[stamp_count] = s_tdata[STAMP_W-1:0];
                    stamp_count++;
                end
            end
        end
        pending_results <= index_queue.size();
    end

endmodule

[test/nearest_timestamp_search_tb.sv]
// Testbench top for the nearest timestamp search block: clock, reset, request stimulus and verdict.
module nearest_timestamp_search_tb;
    import nts_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [31:0] time_value
    logic [0:0]           s_tuser;   // [0] kind
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [9:0] nearest_index, [15:10] zero

    int fail_count;
    int pending_results;

    // Idle and stall chances in percent, set per phase.
    int idle_pct;
    int stall_pct;
    bit hold_req;
    bit hold_taken;

    // Stamps loaded so far, used only to aim queries at interesting times.
    logic [STAMP_W-1:0] loaded [TABLE_DEPTH];
    int                 n_loaded;
    logic [STAMP_W-1:0] last_stamp;

    nearest_timestamp_search dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nearest_timestamp_search_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin
        m_tready   = 1'b0;
        hold_taken = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_request(input logic kind, input logic [STAMP_W-1:0] t);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= t;
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic load_stamp(input logic [STAMP_W-1:0] t);
        send_request(KIND_LOAD, t);
        if (n_loaded < TABLE_DEPTH) begin
            loaded[n_loaded] = t;
            n_loaded++;
        end
    endtask

    task automatic query_time(input logic [STAMP_W-1:0] t);
        send_request(KIND_QUERY, t);
    endtask

    // Next ascending stamp: duplicates, tiny steps for ties, and wide gaps.
    task automatic load_next_stamp();
        logic [STAMP_W:0] sum;
        logic [STAMP_W-1:0] gap;
        case ($urandom_range(0, 9))
            0:       gap = '0;
            1, 2, 3: gap = $urandom_range(1, 4);
            default: gap = $urandom_range(1, 1 << 22);
        endcase
        sum        = {1'b0, last_stamp} + gap;
        last_stamp = sum[STAMP_W] ? '1 : sum[STAMP_W-1:0];
        load_stamp(last_stamp);
    endtask

    function automatic logic [STAMP_W-1:0] pick_query_time();
        int                 i;
        logic [STAMP_W-1:0] a;
        logic [STAMP_W-1:0] b;
        if (n_loaded == 0)
            return $urandom;
        i = $urandom_range(0, n_loaded - 1);
        a = loaded[i];
        b = (i + 1 < n_loaded) ? loaded[i + 1] : a;
        case ($urandom_range(0, 9))
            0, 1, 2: return a;
            3, 4:    return a + $urandom_range(0, 4) - 2;
            5, 6:    return a + (b - a) / 2 + $urandom_range(0, 2) - 1;
            7:       return $urandom;
            8:       return $urandom_range(0, 3);
            default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
    endfunction

    task automatic run_mixed(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 40 && n_loaded < TABLE_DEPTH)
                load_next_stamp();
            else
                query_time(pick_query_time());
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_LOAD;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_req   = 1'b0;
        n_loaded   = 0;
        last_stamp = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty table, then a one-entry table: every query answers zero.
        query_time('0);
        query_time('1);
        load_stamp('0);
        query_time('0);
        query_time('1);
        query_time(32'd7);
        // Small tables: exact hits, a tie halfway, both ends and a duplicate stamp.
        load_stamp(32'd10);
        load_stamp(32'd20);
        query_time(32'd10);
        query_time(32'd15);
        query_time(32'd14);
        query_time(32'd16);
        query_time(32'd20);
        query_time('1);
        load_stamp(32'd20);
        load_stamp(32'd35);
        query_time(32'd20);
        query_time(32'd27);
        query_time(32'd28);
        query_time('0);
        last_stamp = 32'd35;

        run_mixed(125);

        idle_pct = 64;
        run_mixed(125);

        // Long hold-off on the result side while requests keep coming.
        idle_pct  = 0;
        stall_pct = 64;
        hold_req  = 1'b1;
        run_mixed(125);

        idle_pct  = 18;
        stall_pct = 18;
        run_mixed(125);

        idle_pct  = 0;
        stall_pct = 0;
        query_time('1);
        repeat (40) query_time(pick_query_time());

        s_tvalid <= 1'b0;
        while (pending_results != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
